// ----- hdl/sert_pkg.sv -----
package sert_pkg;

  localparam int COORD_W       = 24;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * COORD_W;
  localparam int N2_W          = SQ_W + 1;
  localparam int PROD_W        = DIFF_W + COORD_W;
  localparam int C_W           = PROD_W + 1;
  localparam int CABS_W        = 2 * COORD_W;
  localparam int HALF_W        = CABS_W / 2;
  localparam int C2_W          = 2 * CABS_W;
  localparam int RHO_W         = 24;
  localparam int T_W           = N2_W + RHO_W;
  localparam int SUB_W         = C2_W + 4;
  localparam int THETA_W       = 16;
  localparam int MSB_W         = 5;
  localparam int SHIFT_W       = 6;
  localparam int CX_W          = 42;
  localparam int Z_W           = 34;
  localparam int NORM_EXP      = 38;
  localparam int ANG_TABLE_LEN = 24;
  localparam int CORDIC_STAGES = 16;
  localparam int CORDIC_RUN    = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES
                                                                 : ANG_TABLE_LEN;
  localparam int BACK_STAGES   = RHO_W;
  localparam logic [Z_W-1:0] HALF_PI   = Z_W'(64'h4000_0000);
  localparam logic [Z_W-1:0] ROUND_ADD = Z_W'(64'h8000);

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
  } sert_in_t;

  typedef struct packed {
    logic [RHO_W-1:0]          rho;
    logic signed [THETA_W-1:0] theta;
    logic                      degenerate;
  } sert_out_t;

  // Work carried through the distance and angle stages.
  typedef struct packed {
    logic [C2_W-1:0]       rem;
    logic [T_W-1:0]        tacc;
    logic [N2_W-1:0]       n2;
    logic [RHO_W-1:0]      r;
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    logic                   deg;
    logic                   czero;
  } sert_work_t;

  // atan(2^-i), 2^31 units per pi
  function automatic logic [31:0] atan_unit(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/sert_front.sv -----
module sert_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  sert_pkg::sert_in_t  in_data,
  output logic                out_valid,
  output sert_pkg::sert_work_t out_work
);
  import sert_pkg::*;

  logic [6:0] v_r;

  logic signed [COORD_W-1:0] s1_px_r, s1_py_r;
  logic signed [DIFF_W-1:0]  s1_dx_r, s1_dy_r;

  logic signed [2*DIFF_W-1:0] sqx, sqy;
  logic signed [PROD_W-1:0]   pa, pb;
  logic [SQ_W-1:0]            s2_n2a_r, s2_n2b_r;
  logic signed [PROD_W-1:0]   s2_pa_r, s2_pb_r;
  logic signed [DIFF_W-1:0]   s2_dx_r, s2_dy_r;
  logic                       s2_deg_r;

  logic [N2_W-1:0]          s3_n2_r;
  logic signed [C_W-1:0]    s3_c_r;
  logic signed [DIFF_W-1:0] s3_dx_r, s3_dy_r;
  logic                     s3_deg_r;

  logic [C_W-1:0]           cmag;
  logic                     cpos;
  logic [CABS_W-1:0]        s4_cabs_r;
  logic                     s4_czero_r;
  logic signed [DIFF_W-1:0] s4_vx_r, s4_vy_r;
  logic [N2_W-1:0]          s4_n2_r;
  logic                     s4_deg_r;

  logic [DIFF_W-1:0]        ax, ay;
  logic [SQ_W-1:0]          s5_hh_r, s5_hl_r, s5_ll_r;
  logic [COORD_W-1:0]       s5_mx_r;
  logic signed [DIFF_W-1:0] s5_vx_r, s5_vy_r;
  logic [N2_W-1:0]          s5_n2_r;
  logic                     s5_deg_r, s5_czero_r;

  logic [MSB_W-1:0]         msb;
  logic [C2_W-1:0]          s6_c2_r;
  logic [SHIFT_W-1:0]       s6_k_r;
  logic signed [DIFF_W-1:0] s6_vx_r, s6_vy_r;
  logic [N2_W-1:0]          s6_n2_r;
  logic                     s6_deg_r, s6_czero_r;

  logic signed [CX_W-1:0]   sx, sy;
  sert_work_t               s7_nxt;
  sert_work_t               s7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  // difference vector
  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r <= in_data.first_x;
      s1_py_r <= in_data.first_y;
      s1_dx_r <= {in_data.second_x[COORD_W-1], in_data.second_x}
               - {in_data.first_x[COORD_W-1], in_data.first_x};
      s1_dy_r <= {in_data.second_y[COORD_W-1], in_data.second_y}
               - {in_data.first_y[COORD_W-1], in_data.first_y};
    end
  end

  // products
  assign sqx = s1_dx_r * s1_dx_r;
  assign sqy = s1_dy_r * s1_dy_r;
  assign pa  = s1_dx_r * s1_py_r;
  assign pb  = s1_dy_r * s1_px_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_n2a_r <= sqx[SQ_W-1:0];
      s2_n2b_r <= sqy[SQ_W-1:0];
      s2_pa_r  <= pa;
      s2_pb_r  <= pb;
      s2_dx_r  <= s1_dx_r;
      s2_dy_r  <= s1_dy_r;
      s2_deg_r <= (s1_dx_r == '0) && (s1_dy_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_n2_r  <= N2_W'(s2_n2a_r) + N2_W'(s2_n2b_r);
      s3_c_r   <= C_W'(s2_pa_r) - C_W'(s2_pb_r);
      s3_dx_r  <= s2_dx_r;
      s3_dy_r  <= s2_dy_r;
      s3_deg_r <= s2_deg_r;
    end
  end

  // magnitude of the cross term, and the foot direction pointing away from the origin
  assign cmag = s3_c_r[C_W-1] ? C_W'(-s3_c_r) : C_W'(s3_c_r);
  assign cpos = !s3_c_r[C_W-1] && (s3_c_r != '0);

  always_ff @(posedge clk) begin
    if (en) begin
      s4_cabs_r  <= cmag[CABS_W-1:0];
      s4_czero_r <= (s3_c_r == '0);
      s4_vx_r    <= cpos ? -s3_dy_r : s3_dy_r;
      s4_vy_r    <= cpos ? s3_dx_r : -s3_dx_r;
      s4_n2_r    <= s3_n2_r;
      s4_deg_r   <= s3_deg_r;
    end
  end

  assign ax = s4_vx_r[DIFF_W-1] ? DIFF_W'(-s4_vx_r) : DIFF_W'(s4_vx_r);
  assign ay = s4_vy_r[DIFF_W-1] ? DIFF_W'(-s4_vy_r) : DIFF_W'(s4_vy_r);

  // square of |c| as three partial products
  always_ff @(posedge clk) begin
    if (en) begin
      s5_hh_r    <= s4_cabs_r[CABS_W-1:HALF_W] * s4_cabs_r[CABS_W-1:HALF_W];
      s5_hl_r    <= s4_cabs_r[CABS_W-1:HALF_W] * s4_cabs_r[HALF_W-1:0];
      s5_ll_r    <= s4_cabs_r[HALF_W-1:0] * s4_cabs_r[HALF_W-1:0];
      s5_mx_r    <= (ax > ay) ? ax[COORD_W-1:0] : ay[COORD_W-1:0];
      s5_vx_r    <= s4_vx_r;
      s5_vy_r    <= s4_vy_r;
      s5_n2_r    <= s4_n2_r;
      s5_deg_r   <= s4_deg_r;
      s5_czero_r <= s4_czero_r;
    end
  end

  always_comb begin
    msb = '0;
    for (int i = 0; i < COORD_W; i++) begin
      if (s5_mx_r[i]) msb = MSB_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_c2_r    <= (C2_W'(s5_hh_r) << (2 * HALF_W)) + (C2_W'(s5_hl_r) << (HALF_W + 1))
                  + C2_W'(s5_ll_r);
      s6_k_r     <= SHIFT_W'(NORM_EXP) - SHIFT_W'(msb);
      s6_vx_r    <= s5_vx_r;
      s6_vy_r    <= s5_vy_r;
      s6_n2_r    <= s5_n2_r;
      s6_deg_r   <= s5_deg_r;
      s6_czero_r <= s5_czero_r;
    end
  end

  // normalize, then fold into the right half plane
  assign sx = {{(CX_W-DIFF_W){s6_vx_r[DIFF_W-1]}}, s6_vx_r} <<< s6_k_r;
  assign sy = {{(CX_W-DIFF_W){s6_vy_r[DIFF_W-1]}}, s6_vy_r} <<< s6_k_r;

  always_comb begin
    s7_nxt       = '0;
    s7_nxt.rem   = s6_c2_r;
    s7_nxt.n2    = s6_n2_r;
    s7_nxt.deg   = s6_deg_r;
    s7_nxt.czero = s6_czero_r;
    s7_nxt.cx    = sx;
    s7_nxt.cy    = sy;
    if (sx < 0) begin
      if (sy >= 0) begin
        s7_nxt.cx = sy;
        s7_nxt.cy = -sx;
        s7_nxt.z  = HALF_PI;
      end else begin
        s7_nxt.cx = -sy;
        s7_nxt.cy = sx;
        s7_nxt.z  = -HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r <= s7_nxt;
    end
  end

  assign out_valid = v_r[6];
  assign out_work  = s7_r;

endmodule

// ----- hdl/sert_back.sv -----
module sert_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  sert_pkg::sert_work_t in_work,
  output logic                 out_valid,
  output sert_pkg::sert_work_t out_work
);
  import sert_pkg::*;

  logic [BACK_STAGES-1:0] stg_v_r;
  sert_work_t             stg_r [BACK_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else if (en) begin
      stg_v_r <= {stg_v_r[BACK_STAGES-2:0], in_valid};
    end
  end

  // Each stage settles a rho bit, MSB first; only j < CORDIC_RUN do an angle step.
  for (genvar j = 0; j < BACK_STAGES; j++) begin : g_stage
    localparam int B = RHO_W - 1 - j;
    sert_work_t       cur;
    sert_work_t       nxt;
    logic [SUB_W-1:0] sub;
    logic signed [CX_W-1:0] xs, ys;

    if (j == 0) begin : g_first
      assign cur = in_work;
    end else begin : g_rest
      assign cur = stg_r[j-1];
    end

    always_comb begin
      nxt = cur;
      sub = (SUB_W'(cur.tacc) << (B + 1)) + (SUB_W'(cur.n2) << (2 * B));
      if (SUB_W'(cur.rem) >= sub) begin
        nxt.rem  = cur.rem - sub[C2_W-1:0];
        nxt.r    = cur.r | (RHO_W'(1) << B);
        nxt.tacc = cur.tacc + (T_W'(cur.n2) << B);
      end
      xs = cur.cx >>> j;
      ys = cur.cy >>> j;
      if (j < CORDIC_RUN) begin
        if (cur.cy > 0) begin
          nxt.cx = cur.cx + ys;
          nxt.cy = cur.cy - xs;
          nxt.z  = cur.z + Z_W'(atan_unit(5'(j)));
        end else begin
          nxt.cx = cur.cx - ys;
          nxt.cy = cur.cy + xs;
          nxt.z  = cur.z - Z_W'(atan_unit(5'(j)));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[j] <= nxt;
      end
    end
  end

  assign out_valid = stg_v_r[BACK_STAGES-1];
  assign out_work  = stg_r[BACK_STAGES-1];

endmodule

// ----- hdl/segment_endpoints_to_rho_theta_core.sv -----
// Segment endpoints to polar line form (rho, theta).
// Input channel (in_valid/in_ready/in_data): one request holds both endpoints of a
// segment as signed Q16.8 coordinates. Result channel (out_valid/out_ready/out_data):
// one result per request, in request order: rho as unsigned Q16.8 distance from the
// origin (floor, saturating), theta as a binary angle with pi = 32768, and a
// degenerate flag when the endpoints coincide (rho and theta then 0).
// Throughput: one request per cycle while the receiver takes results. Each result
// passes 7 front stages (differences, products, norm and cross term, foot direction,
// partial squares, square, normalize and fold), 24 stages that each settle one rho
// bit (the first CORDIC_RUN also run a CORDIC iteration), and the output register.
// Reset (rst_n low at a clock edge) empties every stage, the output register and
// the skid register; nothing comes out until new requests go in.
// When the receiver stalls, the output register holds its result and one more
// result lands in the skid register; in_ready then drops and the whole pipeline
// holds until the output drains. No request is lost or repeated.
module segment_endpoints_to_rho_theta_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sert_pkg::sert_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sert_pkg::sert_out_t out_data
);
  import sert_pkg::*;

  logic       en;
  logic       fr_valid;
  sert_work_t fr_work;
  logic       bk_valid;
  sert_work_t bk_work;

  logic [Z_W-1:0] z_round;
  sert_out_t      res;

  logic      out_valid_r;
  sert_out_t out_data_r;
  logic      skid_full_r;
  sert_out_t skid_r;
  logic      out_take;

  // advance the pipeline whenever the skid register is free
  assign en       = !skid_full_r;
  assign in_ready = en;

  sert_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_work  (fr_work)
  );

  sert_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_work   (fr_work),
    .out_valid (bk_valid),
    .out_work  (bk_work)
  );

  // round the angle to 16 bits, halves upward; force zeros for the special cases
  assign z_round = bk_work.z + ROUND_ADD;

  always_comb begin
    res.degenerate = bk_work.deg;
    res.rho        = bk_work.r;
    res.theta      = z_round[31:16];
    if (bk_work.deg || bk_work.czero) begin
      res.rho   = '0;
      res.theta = '0;
    end
  end

  assign out_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      // drain the held result first
      if (out_take) begin
        out_valid_r <= 1'b1;
        skid_full_r <= 1'b0;
      end
    end else if (bk_valid) begin
      if (out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_full_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (out_take) out_data_r <= skid_r;
    end else if (bk_valid) begin
      if (out_take) out_data_r <= res;
      else          skid_r     <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_skid_fill_cause : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_full_r) |-> $past(out_valid_r && !out_ready))
    else $error("skid register filled without a stalled output");

  a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.degenerate) |-> (out_data_r.rho == '0 && out_data_r.theta == '0))
    else $error("degenerate result with nonzero rho or theta");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sert_pkg::*;

  localparam int LATENCY    = 31;
  localparam int DRAIN_WAIT = LATENCY + 20;
  localparam int WATCHDOG   = 5000;
  localparam int N_RANDOM   = 1230;

  // Angle table for the CORDIC, 2^31 units per pi.
  localparam longint ATAN_TBL [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
    64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
    64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

  // Expected results, oldest first, and pass/fail accounting.
  class line_scoreboard;
    sert_out_t pending[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned degenerate_seen;

    // Floor distance: largest r with r^2*|D|^2 <= c^2.
    static function automatic logic [23:0] floor_distance(logic [127:0] cabs,
                                                          logic [127:0] n2);
      logic [127:0] c2;
      logic [127:0] cand;
      logic [23:0]  r;
      c2 = cabs * cabs;
      r  = '0;
      for (int b = 23; b >= 0; b--) begin
        cand = {104'd0, r | (24'd1 << b)};
        if (cand * cand * n2 <= c2) r = cand[23:0];
      end
      return r;
    endfunction

    static function automatic longint floor_shift(longint v, int s);
      return v >>> s;
    endfunction

    // Vectoring CORDIC on (x, y), rounded to 2^15 units per pi.
    static function automatic logic [15:0] vector_heading(longint x, longint y);
      longint z;
      longint t;
      longint xs;
      longint ys;
      logic [63:0] zr;
      z = 0;
      while (x > -(64'sd1 << 38) && x < (64'sd1 << 38) &&
             y > -(64'sd1 << 38) && y < (64'sd1 << 38)) begin
        x = x * 2;
        y = y * 2;
      end
      // fold into the right half plane
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = 64'sd1 << 30;
        end else begin
          x = -y; y = t; z = -(64'sd1 << 30);
        end
      end
      for (int i = 0; i < CORDIC_RUN; i++) begin
        xs = floor_shift(x, i);
        ys = floor_shift(y, i);
        if (y > 0) begin
          x += ys; y -= xs; z += ATAN_TBL[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_TBL[i];
        end
      end
      zr = z + 64'h8000;
      return zr[31:16];
    endfunction

    function void note_request(sert_in_t req);
      longint px, py, dx, dy, c;
      logic [127:0] n2;
      sert_out_t exp_res;
      px = longint'(req.first_x);
      py = longint'(req.first_y);
      dx = longint'(req.second_x) - px;
      dy = longint'(req.second_y) - py;
      n2 = 128'(dx * dx) + 128'(dy * dy);
      exp_res = '0;
      if (n2 == 0) begin
        exp_res.degenerate = 1'b1;
      end else begin
        c = dx * py - dy * px;
        if (c != 0) begin
          exp_res.rho = floor_distance(128'(c < 0 ? -c : c), n2);
          exp_res.theta = (c > 0) ? vector_heading(-dy, dx) : vector_heading(dy, -dx);
        end
      end
      pending.push_back(exp_res);
    endfunction

    function void check_result(sert_out_t got);
      sert_out_t exp_res;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result rho=%0d theta=%0d deg=%0b",
                   got.rho, got.theta, got.degenerate);
        return;
      end
      exp_res = pending.pop_front();
      if (got.degenerate) degenerate_seen++;
      if (got.rho !== exp_res.rho || got.theta !== exp_res.theta ||
          got.degenerate !== exp_res.degenerate) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: exp rho=%0d theta=%0d deg=%0b, got rho=%0d theta=%0d deg=%0b",
                   checked, exp_res.rho, exp_res.theta, exp_res.degenerate,
                   got.rho, got.theta, got.degenerate);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sert_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  sert_out_t out_data;

  line_scoreboard sb;
  bit          stim_done;
  bit          hold_sink;   // long receiver hold-off in effect
  bit          sink_idle_on;
  int unsigned idle_cycles;
  int unsigned accepted;

  segment_endpoints_to_rho_theta_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Score both channels at the rising edge; count cycles without progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_request(in_data);
        accepted++;
      end
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (stim_done && sb.pending.size() == 0))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic logic signed [23:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return 24'sh7FFFFF;
      1:       return -24'sh800000;
      2:       return 24'($signed($urandom_range(0, 4095)) - 2048);
      3:       return 24'($signed($urandom_range(0, 255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  // Offer one request and hold it until accepted, after the given gap.
  // Valid drops only across a gap, so back-to-back requests keep it high.
  task automatic send_segment(sert_in_t seg, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_points(int ax, int ay, int bx, int by);
    sert_in_t seg;
    seg.first_x  = 24'(ax);
    seg.first_y  = 24'(ay);
    seg.second_x = 24'(bx);
    seg.second_y = 24'(by);
    send_segment(seg, 0);
  endtask

  // Receiver: random stalls, with stall-free bursts.
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        out_ready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 9) < 4) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    sert_in_t seg;
    int gap_on;
    int degen_n;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    stim_done = 1'b0;
    hold_sink = 1'b0;
    sink_idle_on = 1'b0;
    idle_cycles = 0;
    accepted = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, coincident endpoints, lines through the origin,
    // axis-aligned lines, the angle of pi wrapping to -32768.
    send_points(0, 0, 0, 0);
    send_points(-8388608, 8388607, -8388608, 8388607);
    send_points(-256, -256, 256, 256);
    send_points(0, 0, 1000, 7);
    send_points(-8388608, -8388608, 8388607, 8388607);
    send_points(-8388608, 8388607, 8388607, -8388608);
    send_points(-8388608, -8388608, -8388608, 8388607);
    send_points(8388607, -8388608, 8388607, 8388607);
    send_points(-8388608, -8388608, 8388607, -8388608);
    send_points(-8388608, 8388607, 8388607, 8388607);
    send_points(-256, 100, -256, -100);
    send_points(-256, -100, -256, 100);
    send_points(256, 0, 256, 1);
    send_points(0, 256, 1, 256);
    send_points(0, -256, 1, -256);
    send_points(1, 0, 1, 1);
    send_points(-8388608, 0, -8388607, 1);
    send_points(8388607, -8388608, -8388608, 8388607);
    send_points(100, 200, 101, 200);
    send_points(8388607, 8388607, 8388606, 8388607);
    send_points(-1, -1, -1, -2);

    // Random: short segments mostly, some full-range, some coincident.
    sink_idle_on = 1'b1;
    gap_on = 1;
    degen_n = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 100) gap_on = !gap_on;
      sink_idle_on = (n % 300) < 220;
      if (n == 400) begin
        // Hold off the receiver; keep offering until the input stalls.
        hold_sink = 1'b1;
        fork
          begin
            repeat (150) @(negedge clk);
            hold_sink = 1'b0;
          end
        join_none
      end
      if (n == 700) begin
        // Pause the sender until every expected result has arrived.
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0) @(negedge clk);
      end
      seg.first_x = pick_coord();
      seg.first_y = pick_coord();
      case ($urandom_range(0, 9))
        0: begin
          seg.second_x = seg.first_x;
          seg.second_y = seg.first_y;
          degen_n++;
        end
        1, 2, 3: begin
          seg.second_x = pick_coord();
          seg.second_y = pick_coord();
        end
        default: begin
          seg.second_x = seg.first_x + 24'($signed($urandom_range(0, 8191)) - 4096);
          seg.second_y = seg.first_y + 24'($signed($urandom_range(0, 8191)) - 4096);
        end
      endcase
      send_segment(seg, (gap_on || n >= 400 && n < 420) ? $urandom_range(0, 9) : 0);
    end
    in_valid <= 1'b0;

    stim_done = 1'b1;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    $display("Ran %0d segments (%0d results checked, %0d degenerate flagged)",
             accepted, sb.checked, sb.degenerate_seen);
    $display("with random stalls on both sides and one long receiver hold-off.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
